### sv/pwlt_pkg.sv
// ----------------------------------------------------------------------------
// pwlt_pkg
// Shared widths, stage payload types and segment tables for the
// piecewise-linear tanh pipeline.
// ----------------------------------------------------------------------------
package pwlt_pkg;

   localparam int unsigned DATA_W     = 32;
   localparam int unsigned MAG_W      = 31;
   localparam int unsigned SEG_COUNT  = 16;
   localparam int unsigned SEG_W      = $clog2(SEG_COUNT);
   localparam int unsigned COEF_W     = 31;
   localparam int unsigned PROD_W     = MAG_W + COEF_W;
   localparam int unsigned FRAC_SHIFT = 27;
   localparam int unsigned HI_W       = PROD_W - FRAC_SHIFT;
   localparam int unsigned SUM_W      = HI_W + 1;

   // band edges below the top one; the top edge is 2^31 and takes every magnitude
   localparam logic [MAG_W-1:0] EDGE_TAB [SEG_COUNT-1] = '{
      31'd33584191,  31'd58182438,  31'd80361293,  31'd102120620,
      31'd124483371, 31'd148392654, 31'd174972063, 31'd206183541,
      31'd244722657, 31'd281591256, 31'd312045360, 31'd358241226,
      31'd403095772, 31'd471425623, 31'd530372454
   };

   localparam logic [COEF_W-1:0] SLOPE_TAB [SEG_COUNT] = '{
      31'd2114623134, 31'd1910645334, 31'd1662969581, 31'd1396521636,
      31'd1131979061, 31'd881027392,  31'd652221876,  31'd451080022,
      31'd281798391,  31'd159724746,  31'd98692663,   31'd60001039,
      31'd27632752,   31'd13732196,   31'd2832019,    31'd172634
   };

   localparam logic [COEF_W-1:0] BIAS_TAB [SEG_COUNT] = '{
      31'd0,          31'd51039676,   31'd158405367,  31'd317937954,
      31'd519217264,  31'd751968259,  31'd1004938252, 31'd1267155516,
      31'd1527203771, 31'd1749783808, 31'd1877830237, 31'd1967785133,
      31'd2054179492, 31'd2095926998, 31'd2134212723, 31'd2144721503
   };

   typedef struct packed {
      logic             neg;
      logic [SEG_W-1:0] seg;
      logic [MAG_W-1:0] mag;
   } s1_type;

   typedef struct packed {
      logic              neg;
      logic [SEG_W-1:0]  seg;
      logic [PROD_W-1:0] prod;
   } s2_type;

endpackage

### sv/pwlt_seg.sv
// ----------------------------------------------------------------------------
// pwlt_seg
// First stage: magnitude of the sample and band selection.
// ----------------------------------------------------------------------------
module pwlt_seg (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   input  logic [pwlt_pkg::DATA_W-1:0]   sample,
   output logic                          valid_ff,
   output pwlt_pkg::s1_type              stage_ff
);
   import pwlt_pkg::*;

   logic                 valid_in;
   s1_type               stage_in;
   logic [MAG_W-1:0]     mag;
   logic [DATA_W-1:0]    negated;
   logic [SEG_COUNT-2:0] below;
   logic [SEG_W-1:0]     seg;

   always_comb begin
      negated = DATA_W'(0) - sample;
      if (!sample[DATA_W-1]) begin
         mag = sample[MAG_W-1:0];
      end else if (sample[MAG_W-1:0] == '0) begin
         // most negative sample clamps to the largest magnitude
         mag = '1;
      end else begin
         mag = negated[MAG_W-1:0];
      end
   end

   always_comb begin
      for (int k = 0; k < SEG_COUNT - 1; k++) begin
         below[k] = (mag <= EDGE_TAB[k]);
      end
      // lowest band whose edge covers the magnitude
      seg = SEG_W'(SEG_COUNT - 1);
      for (int k = SEG_COUNT - 2; k >= 0; k--) begin
         if (below[k]) begin
            seg = SEG_W'(k);
         end
      end
   end

   assign valid_in       = in_valid;
   assign stage_in.neg   = sample[DATA_W-1];
   assign stage_in.seg   = seg;
   assign stage_in.mag   = mag;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      stage_ff <= stage_in;
   end

endmodule

### sv/pwlt_mul.sv
// ----------------------------------------------------------------------------
// pwlt_mul
// Second stage: slope lookup and magnitude times slope.
// ----------------------------------------------------------------------------
module pwlt_mul (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   input  pwlt_pkg::s1_type  stage,
   output logic              valid_ff,
   output pwlt_pkg::s2_type  stage_ff
);
   import pwlt_pkg::*;

   logic        valid_in;
   s2_type      stage_in;
   logic [COEF_W-1:0] slope;

   assign slope         = SLOPE_TAB[stage.seg];
   assign valid_in      = in_valid;
   assign stage_in.neg  = stage.neg;
   assign stage_in.seg  = stage.seg;
   assign stage_in.prod = PROD_W'(stage.mag) * PROD_W'(slope);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      stage_ff <= stage_in;
   end

endmodule

### sv/pwlt_out.sv
// ----------------------------------------------------------------------------
// pwlt_out
// Third stage: scale down, add the bias, saturate and restore the sign.
// ----------------------------------------------------------------------------
module pwlt_out (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   input  pwlt_pkg::s2_type              stage,
   output logic                          valid_ff,
   output logic [pwlt_pkg::DATA_W-1:0]   result_ff
);
   import pwlt_pkg::*;

   localparam logic [SUM_W-1:0] POS_MAX = SUM_W'(33'h0_7FFF_FFFF);
   localparam logic [SUM_W-1:0] NEG_MAX = SUM_W'(33'h0_8000_0000);

   logic              valid_in;
   logic [DATA_W-1:0] result_in;
   logic [HI_W-1:0]   hi;
   logic              round_up;
   logic [SUM_W-1:0]  sum;
   logic [DATA_W-1:0] neg_mag;

   assign hi       = stage.prod[PROD_W-1:FRAC_SHIFT];
   // negative path rounds the magnitude up, giving floor of the negated product
   assign round_up = stage.neg & (|stage.prod[FRAC_SHIFT-1:0]);
   assign sum      = SUM_W'(hi) + SUM_W'(BIAS_TAB[stage.seg]) + SUM_W'(round_up);

   always_comb begin
      neg_mag = (sum > NEG_MAX) ? NEG_MAX[DATA_W-1:0] : sum[DATA_W-1:0];
      if (stage.neg) begin
         result_in = DATA_W'(0) - neg_mag;
      end else if (sum > POS_MAX) begin
         result_in = POS_MAX[DATA_W-1:0];
      end else begin
         result_in = sum[DATA_W-1:0];
      end
   end

   assign valid_in = in_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      result_ff <= result_in;
   end

endmodule

### sv/piecewise_linear_tanh.sv
// ----------------------------------------------------------------------------
// piecewise_linear_tanh
// Sixteen-segment piecewise-linear tanh, Q27-ish in, Q31-ish out.
// ----------------------------------------------------------------------------
// One sample is taken at every clock where start is high; busy stays low, so
// samples may be issued back to back without gaps. Each sample yields exactly
// one result, shown on rsp_tanh_out for a single cycle with rsp_valid high,
// in issue order. The three register stages are band select, the 31x31 slope
// multiply, and bias add with saturation. Results are not buffered and must be
// taken when shown.
module piecewise_linear_tanh (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [pwlt_pkg::DATA_W-1:0]   req_sample_in,
   output logic                          rsp_valid,
   output logic [pwlt_pkg::DATA_W-1:0]   rsp_tanh_out
);
   import pwlt_pkg::*;

   logic   accept;
   logic   s1_valid;
   s1_type s1_stage;
   logic   s2_valid;
   s2_type s2_stage;

   assign busy   = 1'b0;
   assign accept = start & ~busy;

   pwlt_seg u_seg (
      .clock    (clock),
      .reset    (reset),
      .in_valid (accept),
      .sample   (req_sample_in),
      .valid_ff (s1_valid),
      .stage_ff (s1_stage)
   );

   pwlt_mul u_mul (
      .clock    (clock),
      .reset    (reset),
      .in_valid (s1_valid),
      .stage    (s1_stage),
      .valid_ff (s2_valid),
      .stage_ff (s2_stage)
   );

   pwlt_out u_out (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s2_valid),
      .stage     (s2_stage),
      .valid_ff  (rsp_valid),
      .result_ff (rsp_tanh_out)
   );

   // every result beat traces back to an accepted sample, through the seg, mul and out stage registers
   a_rsp_has_req: assert property (@(posedge clock)
      rsp_valid |-> $past(accept, 3))
      else $error("result beat without a matching sample");

   a_req_gets_rsp: assert property (@(posedge clock) disable iff (reset)
      accept |-> ##3 rsp_valid)
      else $error("accepted sample produced no result");

   // tanh keeps the sign of its argument; zero maps to zero
   a_sign_kept: assert property (@(posedge clock)
      rsp_valid |-> (rsp_tanh_out[DATA_W-1] == $past(req_sample_in[DATA_W-1], 3)))
      else $error("result sign differs from sample sign");

   a_zero_kept: assert property (@(posedge clock)
      (rsp_valid && ($past(req_sample_in, 3) == '0)) |-> (rsp_tanh_out == '0))
      else $error("zero sample gave nonzero result");

endmodule

### tb/tanh_result_checker.sv
// ----------------------------------------------------------------------------
// tanh_result_checker
// Watches the sample and result channels of piecewise_linear_tanh, predicts
// the tanh value of every accepted sample and compares it, in order, with the
// results that come out. Hands its failure count and the number of results
// still outstanding to the testbench top.
// ----------------------------------------------------------------------------
module tanh_result_checker (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic                        busy,
   input  logic [pwlt_pkg::DATA_W-1:0] req_sample_in,
   input  logic                        rsp_valid,
   input  logic [pwlt_pkg::DATA_W-1:0] rsp_tanh_out,
   output int                          error_count,
   output int                          pending_count
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned Q_SHIFT    = 27;
   localparam int          REPORT_MAX = 10;

   // upper band edges, inclusive; the last one covers every magnitude
   localparam logic [31:0] BAND_EDGE [16] = '{
      32'd33584191,  32'd58182438,  32'd80361293,  32'd102120620,
      32'd124483371, 32'd148392654, 32'd174972063, 32'd206183541,
      32'd244722657, 32'd281591256, 32'd312045360, 32'd358241226,
      32'd403095772, 32'd471425623, 32'd530372454, 32'h8000_0000
   };

   localparam logic [31:0] BAND_SLOPE [16] = '{
      32'd2114623134, 32'd1910645334, 32'd1662969581, 32'd1396521636,
      32'd1131979061, 32'd881027392,  32'd652221876,  32'd451080022,
      32'd281798391,  32'd159724746,  32'd98692663,   32'd60001039,
      32'd27632752,   32'd13732196,   32'd2832019,    32'd172634
   };

   localparam logic [31:0] BAND_BIAS [16] = '{
      32'd0,          32'd51039676,   32'd158405367,  32'd317937954,
      32'd519217264,  32'd751968259,  32'd1004938252, 32'd1267155516,
      32'd1527203771, 32'd1749783808, 32'd1877830237, 32'd1967785133,
      32'd2054179492, 32'd2095926998, 32'd2134212723, 32'd2144721503
   };

   logic [pwlt_pkg::DATA_W-1:0] expected_tanh_q [$];
   logic [pwlt_pkg::DATA_W-1:0] tanh_want;
   int                          error_total;

   function automatic logic [31:0] tanh_pwl_value(input logic [31:0] sample);
      logic [31:0] mag;
      logic [63:0] prod;
      logic [63:0] acc;
      int          band;
      if (!sample[31]) begin
         mag = sample;
      end else if (sample == 32'h8000_0000) begin
         mag = 32'h7FFF_FFFF;
      end else begin
         mag = -sample;
      end
      band = 15;
      for (int k = 15; k >= 0; k--) begin
         if (mag <= BAND_EDGE[k]) band = k;
      end
      prod = 64'(BAND_SLOPE[band]) * 64'(mag);
      if (!sample[31]) begin
         acc = (prod >> Q_SHIFT) + 64'(BAND_BIAS[band]);
         if (acc > 64'h7FFF_FFFF) acc = 64'h7FFF_FFFF;
         return acc[31:0];
      end
      // floor of the negated product is minus its ceiling
      acc = ((prod + 64'((64'd1 << Q_SHIFT) - 64'd1)) >> Q_SHIFT) + 64'(BAND_BIAS[band]);
      if (acc > 64'h8000_0000) acc = 64'h8000_0000;
      return -acc[31:0];
   endfunction

   task automatic note_error(input string what, input logic [31:0] want,
                             input logic [31:0] got);
      error_total++;
      if (error_total <= REPORT_MAX) begin
         $display("%0t: %s: expected %h got %h", $realtime, what, want, got);
      end
   endtask

   initial begin
      error_total = 0;
   end

   always @(posedge clock) begin
      if (reset) begin
         expected_tanh_q.delete();
      end else begin
         if (start && !busy) begin
            expected_tanh_q.push_back(tanh_pwl_value(req_sample_in));
         end
         if (rsp_valid) begin
            if (expected_tanh_q.size() == 0) begin
               note_error("result beat with no sample pending", 'x, rsp_tanh_out);
            end else begin
               tanh_want = expected_tanh_q.pop_front();
               if (rsp_tanh_out !== tanh_want) begin
                  note_error("tanh_out mismatch", tanh_want, rsp_tanh_out);
               end
            end
         end
      end
      error_count   <= error_total;
      pending_count <= expected_tanh_q.size();
   end

endmodule

### tb/piecewise_linear_tanh_test.sv
// ----------------------------------------------------------------------------
// piecewise_linear_tanh_test
// Drives piecewise_linear_tanh with band edges, range extremes and random
// samples under several sender idle rates; the checker beside the block
// predicts and compares every result, and this top gives the verdict.
// ----------------------------------------------------------------------------
module piecewise_linear_tanh_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int IDLE_LIMIT    = 2000;
   localparam int SETTLE_CYCLES = 8;
   localparam int RANDOM_ITEMS  = 1650;
   localparam int PHASE_COUNT   = 5;

   localparam logic [31:0] DIRECTED_SAMPLES [20] = '{
      32'd0,            32'd1,            32'hFFFF_FFFF,    32'h7FFF_FFFF,
      32'h8000_0000,    32'h8000_0001,    32'd33584191,     32'd33584192,
      -32'd33584191,    -32'd33584192,    32'd206183541,    32'd206183542,
      -32'd206183541,   -32'd206183542,   32'd530372454,    32'd530372455,
      -32'd530372454,   -32'd530372455,   32'd134217728,    -32'd134217728
   };

   localparam int PHASE_IDLE_PCT [PHASE_COUNT] = '{0, 63, 14, 0, 63};

   logic                        clock;
   logic                        reset;
   logic                        start;
   logic                        busy;
   logic [pwlt_pkg::DATA_W-1:0] req_sample_in;
   logic                        rsp_valid;
   logic [pwlt_pkg::DATA_W-1:0] rsp_tanh_out;
   int                          error_count;
   int                          pending_count;
   int                          idle_cycles = 0;
   int                          idle_pct;

   piecewise_linear_tanh u_dut (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_sample_in (req_sample_in),
      .rsp_valid     (rsp_valid),
      .rsp_tanh_out  (rsp_tanh_out)
   );

   tanh_result_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_sample_in (req_sample_in),
      .rsp_valid     (rsp_valid),
      .rsp_tanh_out  (rsp_tanh_out),
      .error_count   (error_count),
      .pending_count (pending_count)
   );

   initial clock = 1'b0;
   always #1 clock = ~clock;

   always @(posedge clock) begin
      if ((start && !busy) || rsp_valid) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // one sample beat, after a random run of idle cycles
   task automatic drive_sample(input logic [31:0] value);
      while ($urandom_range(99) < idle_pct) begin
         start         <= 1'b0;
         req_sample_in <= $urandom;
         @(posedge clock);
      end
      start         <= 1'b1;
      req_sample_in <= value;
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   function automatic logic [31:0] random_sample();
      logic [31:0] mag;
      case ($urandom_range(9))
         0, 1, 2, 3: return $urandom;
         4, 5, 6, 7: mag = $urandom_range(600000000);
         default: begin
            // land on or right beside a band edge
            mag = 32'(pwlt_pkg::EDGE_TAB[$urandom_range(14)]) + 32'($urandom_range(4)) - 32'd2;
         end
      endcase
      return $urandom_range(1) ? -mag : mag;
   endfunction

   initial begin
      reset         = 1'b1;
      start         = 1'b0;
      req_sample_in = '0;
      idle_pct      = 0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      foreach (DIRECTED_SAMPLES[i]) drive_sample(DIRECTED_SAMPLES[i]);

      for (int p = 0; p < PHASE_COUNT; p++) begin
         idle_pct = PHASE_IDLE_PCT[p];
         repeat (RANDOM_ITEMS / PHASE_COUNT) drive_sample(random_sample());
      end
      start <= 1'b0;

      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      if (error_count == 0 && pending_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

### sim.f
sv/pwlt_pkg.sv
sv/pwlt_seg.sv
sv/pwlt_mul.sv
sv/pwlt_out.sv
sv/piecewise_linear_tanh.sv
tb/tanh_result_checker.sv
tb/piecewise_linear_tanh_test.sv
